>>> sv/gitm_pkg.sv
package gitm_pkg;

  // Cell and texture geometry
  localparam int CELL_SIZE    = 8;
  localparam int TEXTURE_LOG2 = 8;

  // floor(log2(CELL_SIZE)): edge and row steps are divided by this power of two
  localparam int STEP_SHIFT = $clog2(CELL_SIZE + 1) - 1;

  localparam int CNT_W   = $clog2(CELL_SIZE);
  localparam int IDX_W   = 3;
  localparam int ADDR_W  = 2 * TEXTURE_LOG2;
  localparam int DEPTH   = 1 << ADDR_W;
  localparam int COORD_W = 32;
  localparam int IN_W    = 24;
  localparam int FRAC_W  = 8;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_RENDER = 1'b1;

  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CELL_SIZE - 1);

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [7:0]         texel_t;

  // Tag that travels with each texture read
  typedef struct packed {
    logic [CNT_W-1:0] row;
    logic [CNT_W-1:0] col;
    logic             last;
  } pix_tag_t;

  function automatic coord_t sext_coord(input logic [IN_W-1:0] x);
    sext_coord = {{(COORD_W - IN_W){x[IN_W-1]}}, x};
  endfunction

  function automatic coord_t asr_step(input coord_t x);
    asr_step = coord_t'($signed(x) >>> STEP_SHIFT);
  endfunction

  // Texel index {u[int], v[int]} cut to the texture side
  function automatic addr_t texel_index(input coord_t u, input coord_t v);
    texel_index = {u[FRAC_W +: TEXTURE_LOG2], v[FRAC_W +: TEXTURE_LOG2]};
  endfunction

endpackage

>>> sv/gitm_texture_ram.sv
module gitm_texture_ram
  import gitm_pkg::*;
(
  input  logic   clk,
  input  logic   wr_en,
  input  addr_t  wr_addr,
  input  texel_t wr_data,
  input  logic   rd_en,
  input  addr_t  rd_addr,
  output texel_t rd_data
);

  texel_t mem [DEPTH];
  texel_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold the read word until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/gitm_walker.sv
module gitm_walker
  import gitm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [IN_W-1:0]  tl_u,
  input  logic [IN_W-1:0]  tl_v,
  input  logic [IN_W-1:0]  tr_u,
  input  logic [IN_W-1:0]  tr_v,
  input  logic [IN_W-1:0]  bl_u,
  input  logic [IN_W-1:0]  bl_v,
  input  logic [IN_W-1:0]  br_u,
  input  logic [IN_W-1:0]  br_v,
  input  logic             take,
  output logic             busy,
  output logic             issue,
  output logic             free,
  output addr_t            rd_addr,
  output pix_tag_t         tag
);

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] row_r, row_nxt, col_r, col_nxt;
  coord_t u_r, u_nxt, v_r, v_nxt;
  coord_t lu_r, lu_nxt, lv_r, lv_nxt;
  coord_t wu_r, wu_nxt, wv_r, wv_nxt;
  coord_t ldu_r, ldv_r, rdu_r, rdv_r, dwu_r, dwv_r;
  coord_t c_tlu, c_tlv, c_tru, c_trv, c_blu, c_blv, c_bru, c_brv;
  logic   row_end, cell_end;

  assign c_tlu = sext_coord(tl_u);
  assign c_tlv = sext_coord(tl_v);
  assign c_tru = sext_coord(tr_u);
  assign c_trv = sext_coord(tr_v);
  assign c_blu = sext_coord(bl_u);
  assign c_blv = sext_coord(bl_v);
  assign c_bru = sext_coord(br_u);
  assign c_brv = sext_coord(br_v);

  assign issue    = busy_r && take;
  assign row_end  = (col_r == CNT_LAST);
  assign cell_end = row_end && (row_r == CNT_LAST);
  assign free     = !busy_r || (issue && cell_end);
  assign busy     = busy_r;
  assign rd_addr  = texel_index(u_r, v_r);
  assign tag      = '{row: row_r, col: col_r, last: cell_end};

  always_comb begin
    busy_nxt = busy_r;
    row_nxt  = row_r;
    col_nxt  = col_r;
    u_nxt    = u_r;
    v_nxt    = v_r;
    lu_nxt   = lu_r;
    lv_nxt   = lv_r;
    wu_nxt   = wu_r;
    wv_nxt   = wv_r;
    if (issue) begin
      if (row_end) begin
        // next row: advance left edge, widen span by the edge-step difference
        col_nxt = '0;
        row_nxt = row_r + 1'b1;
        lu_nxt  = lu_r + ldu_r;
        lv_nxt  = lv_r + ldv_r;
        u_nxt   = lu_r + ldu_r;
        v_nxt   = lv_r + ldv_r;
        wu_nxt  = wu_r + dwu_r;
        wv_nxt  = wv_r + dwv_r;
        if (cell_end) begin
          busy_nxt = 1'b0;
        end
      end else begin
        col_nxt = col_r + 1'b1;
        u_nxt   = u_r + asr_step(wu_r);
        v_nxt   = v_r + asr_step(wv_r);
      end
    end
    if (start) begin
      busy_nxt = 1'b1;
      row_nxt  = '0;
      col_nxt  = '0;
      u_nxt    = c_tlu;
      v_nxt    = c_tlv;
      lu_nxt   = c_tlu;
      lv_nxt   = c_tlv;
      wu_nxt   = c_tru - c_tlu;
      wv_nxt   = c_trv - c_tlv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      row_r  <= '0;
      col_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end
  end

  always_ff @(posedge clk) begin
    u_r  <= u_nxt;
    v_r  <= v_nxt;
    lu_r <= lu_nxt;
    lv_r <= lv_nxt;
    wu_r <= wu_nxt;
    wv_r <= wv_nxt;
    if (start) begin
      ldu_r <= asr_step(c_blu - c_tlu);
      ldv_r <= asr_step(c_blv - c_tlv);
      rdu_r <= asr_step(c_bru - c_tru);
      rdv_r <= asr_step(c_brv - c_trv);
    end
    // registered from the edge steps that start loads; settles well before the first row change
    dwu_r <= rdu_r - ldu_r;
    dwv_r <= rdv_r - ldv_r;
  end

endmodule

>>> sv/gitm_pixel_pipe.sv
module gitm_pixel_pipe
  import gitm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             issue,
  input  pix_tag_t         tag,
  input  texel_t           rd_data,
  output logic             take,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_pixel_row,
  output logic [IDX_W-1:0] out_pixel_column,
  output texel_t           out_pixel_value,
  output logic             out_last_pixel
);

  logic     s1_v_r, s1_v_nxt;
  pix_tag_t s1_tag_r;
  logic     out_v_r, out_v_nxt;
  pix_tag_t out_tag_r;
  texel_t   out_value_r;
  logic     s1_move;

  assign s1_move = s1_v_r && (!out_v_r || out_ready);
  assign take    = !s1_v_r || s1_move;

  always_comb begin
    s1_v_nxt  = issue || (s1_v_r && !s1_move);
    out_v_nxt = s1_move || (out_v_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_tag_r <= tag;
    end
    if (s1_move) begin
      out_tag_r   <= s1_tag_r;
      out_value_r <= rd_data;
    end
  end

  assign out_valid        = out_v_r;
  assign out_pixel_row    = IDX_W'(out_tag_r.row);
  assign out_pixel_column = IDX_W'(out_tag_r.col);
  assign out_pixel_value  = out_value_r;
  assign out_last_pixel   = out_tag_r.last;

endmodule

>>> sv/grid_interpolated_texture_mapper.sv
// Grid-interpolated texture mapper.
//
// Input channel (in_valid / in_ready): one word is either a texel load
// (in_kind = 0: in_texel_value goes to in_texel_address of the 256x256 byte
// texture) or a render (in_kind = 1: four signed 16.8 corner coordinates of one 8x8
// grid cell). A load produces no output word. A render produces 64 output
// words in row-major order, each carrying row, column, the fetched texel and
// a flag on the final pixel.
//
// Throughput: one pixel per cycle while the receiver keeps out_ready high,
// limited by the single read port of the texture RAM. The next render
// is taken in the same cycle as the last pixel address is issued, so cells
// stream with no gap. Loads are taken only while no cell is being walked.
// Path: the first pixel of a cell passes the walker registers, loaded on
// acceptance, then the RAM read register, then the output register.
//
// Reset clears the walker and the output pipeline; the texture RAM is not
// cleared and must be loaded before it is read. When the receiver holds
// out_ready low, the output register and the RAM stage fill and the walker
// holds; nothing is lost.
module grid_interpolated_texture_mapper
  import gitm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             in_kind,
  input  logic [15:0]      in_texel_address,
  input  logic [7:0]       in_texel_value,
  input  logic signed [IN_W-1:0] in_top_left_u,
  input  logic signed [IN_W-1:0] in_top_left_v,
  input  logic signed [IN_W-1:0] in_top_right_u,
  input  logic signed [IN_W-1:0] in_top_right_v,
  input  logic signed [IN_W-1:0] in_bottom_left_u,
  input  logic signed [IN_W-1:0] in_bottom_left_v,
  input  logic signed [IN_W-1:0] in_bottom_right_u,
  input  logic signed [IN_W-1:0] in_bottom_right_v,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_pixel_row,
  output logic [IDX_W-1:0] out_pixel_column,
  output logic [7:0]       out_pixel_value,
  output logic             out_last_pixel
);

  logic     walk_busy, walk_issue, walk_free, pipe_take;
  logic     start, load;
  addr_t    rd_addr;
  texel_t   rd_data;
  pix_tag_t tag;

  // Renders may enter as the previous cell issues its last pixel; loads wait
  // for the walker to drain so earlier cells read the old texture.
  assign in_ready = (in_kind == KIND_RENDER) ? walk_free : !walk_busy;
  assign start    = in_valid && in_ready && (in_kind == KIND_RENDER);
  assign load     = in_valid && in_ready && (in_kind == KIND_LOAD);

  gitm_texture_ram u_ram (
    .clk     (clk),
    .wr_en   (load),
    .wr_addr (ADDR_W'(in_texel_address)),
    .wr_data (in_texel_value),
    .rd_en   (walk_issue),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  gitm_walker u_walker (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .tl_u    (in_top_left_u),
    .tl_v    (in_top_left_v),
    .tr_u    (in_top_right_u),
    .tr_v    (in_top_right_v),
    .bl_u    (in_bottom_left_u),
    .bl_v    (in_bottom_left_v),
    .br_u    (in_bottom_right_u),
    .br_v    (in_bottom_right_v),
    .take    (pipe_take),
    .busy    (walk_busy),
    .issue   (walk_issue),
    .free    (walk_free),
    .rd_addr (rd_addr),
    .tag     (tag)
  );

  gitm_pixel_pipe u_pipe (
    .clk              (clk),
    .rst_n            (rst_n),
    .issue            (walk_issue),
    .tag              (tag),
    .rd_data          (rd_data),
    .take             (pipe_take),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_pixel_row    (out_pixel_row),
    .out_pixel_column (out_pixel_column),
    .out_pixel_value  (out_pixel_value),
    .out_last_pixel   (out_last_pixel)
  );

endmodule

>>> sv/gitm_checker.sv
module gitm_checker
  import gitm_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             out_valid,
  input logic             out_ready,
  input logic [IDX_W-1:0] out_pixel_row,
  input logic [IDX_W-1:0] out_pixel_column,
  input logic [7:0]       out_pixel_value,
  input logic             out_last_pixel
);

  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(CELL_SIZE - 1);

  // hold a stalled word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_pixel_value)
      && $stable(out_pixel_row) && $stable(out_pixel_column)
      && $stable(out_last_pixel))
    else $error("stalled output word changed");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pixel |-> out_pixel_row == IDX_LAST
      && out_pixel_column == IDX_LAST)
    else $error("last flag away from the final corner");

  a_last_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_pixel |=>
      !out_valid || (out_pixel_row == '0 && out_pixel_column == '0))
    else $error("cell after last pixel does not start at its origin");

endmodule

bind grid_interpolated_texture_mapper gitm_checker u_gitm_checker (.*);
